@@ rtl/dsfa_pkg.sv @@
// Shared types and constants for the dust sensor frame averager.
package dsfa_pkg;

  // Frame markers and layout
  localparam logic [7:0] MARK_OPEN  = 8'd170;
  localparam logic [7:0] MARK_CMD   = 8'd192;
  localparam logic [7:0] MARK_TAIL  = 8'd171;
  localparam int         BCNT_W     = 4;
  localparam logic [BCNT_W-1:0] FRAME_LEN = BCNT_W'(10);

  // Field widths
  localparam int PM_W   = 16;
  localparam int USED_W = 11;
  localparam int CODE_W = 3;

  // Default frame count limit
  localparam int MAX_FRAMES_DEF = 1024;

  // Result codes
  typedef enum logic [CODE_W-1:0] {
    CODE_GOOD = 3'd0,
    CODE_CRC  = 3'd1,
    CODE_BAD  = 3'd2,
    CODE_AVG  = 3'd3,
    CODE_NONE = 3'd4
  } code_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;      // input beat accepted this cycle
    logic div_step;  // advance both divider lanes
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_now;  // pending item gives a result
    logic need_div;  // pending item is a finish with data
    logic div_last;  // current divider step is the final one
  } sts_t;

endpackage

@@ rtl/dsfa_ctrl.sv @@
// Controller state machine: handshakes and sequencing of the divide.
module dsfa_ctrl
  import dsfa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd.take     = 1'b0;
    cmd.div_step = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.need_div) begin
            state_nxt = ST_DIV;
          end else if (sts.emit_now) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Input and output sides are never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // A finish with data always starts the divide
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && sts.need_div |=> state_r == ST_DIV)
    else $error("divide not started");

  // The final divide step presents the result
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step && sts.div_last |=> out_valid)
    else $error("average not presented after divide");

endmodule

@@ rtl/dsfa_div_lane.sv @@
// One restoring divider lane: one quotient bit per step.
module dsfa_div_lane
  import dsfa_pkg::*;
#(
  parameter int TOT_W = 27,
  parameter int CNT_W = 11
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [TOT_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [PM_W-1:0]  quot_lo_nxt
);

  logic [TOT_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W:0]   rem_sh;
  logic             ge;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh   = {rem_r, quot_r[TOT_W-1]};
    ge       = rem_sh >= {1'b0, divisor};
    rem_nxt  = ge ? CNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[CNT_W-1:0];
    quot_nxt = {quot_r[TOT_W-2:0], ge};
  end

  assign quot_lo_nxt = quot_nxt[PM_W-1:0];

  // Working registers
  always_ff @(posedge clk) begin
    if (load) begin
      quot_r <= dividend;
      rem_r  <= '0;
    end else if (step) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

@@ rtl/dsfa_datapath.sv @@
// Datapath: frame buffer, checks, running totals, divider and result register.
module dsfa_datapath
  import dsfa_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int CNT_W      = $clog2(MAX_FRAMES + 1),
  parameter int TOT_W      = PM_W + CNT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              in_op,
  input  logic [7:0]        in_data_byte,
  output logic [CODE_W-1:0] out_result_code,
  output logic [PM_W-1:0]   out_pm25_tenths,
  output logic [PM_W-1:0]   out_pm10_tenths,
  output logic [USED_W-1:0] out_frames_used
);

  localparam int STEP_W = $clog2(TOT_W);

  logic [7:0]        frame_r [FRAME_LEN];
  logic [BCNT_W-1:0] byte_cnt_r;
  logic              header_r;
  logic [CNT_W-1:0]  good_r;
  logic [TOT_W-1:0]  tot25_r, tot10_r;
  logic [CNT_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  code_t             code_r;
  logic [PM_W-1:0]   pm25_r, pm10_r;
  logic [USED_W-1:0] used_r;

  logic              is_open, close, frame_bad, crc_bad, frame_good, can_add, add;
  logic [BCNT_W-1:0] idx, byte_cnt_nxt;
  logic [7:0]        sum;
  logic [PM_W-1:0]   v25, v10;
  logic [CNT_W-1:0]  good_nxt;
  logic [PM_W-1:0]   q25_lo_nxt, q10_lo_nxt;
  logic              div_load;

  // Byte position and frame checks
  always_comb begin
    is_open      = in_data_byte == MARK_OPEN;
    close        = is_open && header_r;
    idx          = is_open ? '0 : byte_cnt_r;
    byte_cnt_nxt = (idx <= FRAME_LEN) ? idx + 1'b1 : idx;
    frame_bad    = byte_cnt_r != FRAME_LEN || frame_r[1] != MARK_CMD ||
                   frame_r[9] != MARK_TAIL;
    sum          = frame_r[2] + frame_r[3] + frame_r[4] + frame_r[5] +
                   frame_r[6] + frame_r[7];
    crc_bad      = sum != frame_r[8];
    frame_good   = !frame_bad && !crc_bad;
    v25          = {frame_r[3], frame_r[2]};
    v10          = {frame_r[5], frame_r[4]};
    can_add      = good_r < CNT_W'(MAX_FRAMES);
    add          = close && frame_good && can_add;
    good_nxt     = add ? CNT_W'(good_r + 1'b1) : good_r;
    div_load     = cmd.take && in_op && good_r != '0;
  end

  // Status to controller
  assign sts.emit_now = in_op || close;
  assign sts.need_div = in_op && good_r != '0;
  assign sts.div_last = step_r == '0;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      header_r   <= 1'b0;
      good_r     <= '0;
      tot25_r    <= '0;
      tot10_r    <= '0;
    end else if (cmd.take) begin
      if (in_op) begin
        byte_cnt_r <= '0;
        header_r   <= 1'b0;
        good_r     <= '0;
        tot25_r    <= '0;
        tot10_r    <= '0;
      end else begin
        byte_cnt_r <= byte_cnt_nxt;
        if (is_open) begin
          header_r <= 1'b1;
        end
        good_r <= good_nxt;
        if (add) begin
          tot25_r <= tot25_r + TOT_W'(v25);
          tot10_r <= tot10_r + TOT_W'(v10);
        end
      end
    end
  end

  // Frame buffer
  always_ff @(posedge clk) begin
    if (cmd.take && !in_op && idx < FRAME_LEN) begin
      frame_r[idx] <= in_data_byte;
    end
  end

  // Divisor and step counter
  always_ff @(posedge clk) begin
    if (div_load) begin
      den_r  <= good_r;
      step_r <= STEP_W'(TOT_W - 1);
    end else if (cmd.div_step) begin
      step_r <= step_r - 1'b1;
    end
  end

  dsfa_div_lane #(.TOT_W(TOT_W), .CNT_W(CNT_W)) u_div25 (
    .clk        (clk),
    .load       (div_load),
    .step       (cmd.div_step),
    .dividend   (tot25_r),
    .divisor    (den_r),
    .quot_lo_nxt(q25_lo_nxt)
  );

  dsfa_div_lane #(.TOT_W(TOT_W), .CNT_W(CNT_W)) u_div10 (
    .clk        (clk),
    .load       (div_load),
    .step       (cmd.div_step),
    .dividend   (tot10_r),
    .divisor    (den_r),
    .quot_lo_nxt(q10_lo_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (in_op) begin
        if (good_r == '0) begin
          code_r <= CODE_NONE;
          used_r <= '0;
        end else begin
          code_r <= CODE_AVG;
          used_r <= USED_W'(good_r);
        end
        pm25_r <= '0;
        pm10_r <= '0;
      end else begin
        code_r <= frame_bad ? CODE_BAD : (crc_bad ? CODE_CRC : CODE_GOOD);
        pm25_r <= frame_good ? v25 : '0;
        pm10_r <= frame_good ? v10 : '0;
        used_r <= USED_W'(good_nxt);
      end
    end else if (cmd.div_step && sts.div_last) begin
      pm25_r <= q25_lo_nxt;
      pm10_r <= q10_lo_nxt;
    end
  end

  assign out_result_code = code_r;
  assign out_pm25_tenths = pm25_r;
  assign out_pm10_tenths = pm10_r;
  assign out_frames_used = used_r;

  // Frame count never passes its limit
  a_good_cap: assert property (@(posedge clk) disable iff (!rst_n)
    good_r <= CNT_W'(MAX_FRAMES))
    else $error("frame count past limit");

  // A finish clears the accumulated state
  a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && in_op |=> good_r == '0 && byte_cnt_r == '0 && !header_r)
    else $error("state not cleared by finish");

endmodule

@@ rtl/dust_sensor_frame_averager_core.sv @@
// Top level of the dust sensor frame averager.
// Input channel (in_valid/in_ready): one beat per received serial byte
// (in_op = 0) or a finish request (in_op = 1). A byte 170 opens a frame;
// the next 170 closes it and gives one result beat: good, checksum error
// or malformed, with the frame's PM2.5/PM10 readings when good. Good
// readings are summed for up to MAX_FRAMES frames. A finish gives the
// truncated averages (or no data) and clears all accumulated state.
// Output channel (out_valid/out_ready): one beat per result, held until
// taken; no new input beat is accepted while a result waits, so a stalled
// receiver stalls the input side.
// Timing: a byte that closes a frame shows its result the next cycle.
// A finish with data runs two restoring divider lanes in parallel, one
// quotient bit per cycle, then presents the averages. A finish without
// data answers the next cycle.
// Reset (rst_n, synchronous, low) clears frame tracking, the frame count
// and the totals; the controller sits in idle during reset, so in_ready
// is already high when reset is released.
module dust_sensor_frame_averager_core
  import dsfa_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_result_code,
  output logic [PM_W-1:0]   out_pm25_tenths,
  output logic [PM_W-1:0]   out_pm10_tenths,
  output logic [USED_W-1:0] out_frames_used
);

  cmd_t cmd;
  sts_t sts;

  dsfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsfa_datapath #(.MAX_FRAMES(MAX_FRAMES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_data_byte   (in_data_byte),
    .out_result_code(out_result_code),
    .out_pm25_tenths(out_pm25_tenths),
    .out_pm10_tenths(out_pm10_tenths),
    .out_frames_used(out_frames_used)
  );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the dust sensor frame averager core.
module tb
  import dsfa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Small frame cap so the saturated count is reached within a short run
  localparam int FRAME_CAP   = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    code_t             code;
    logic [PM_W-1:0]   pm25;
    logic [PM_W-1:0]   pm10;
    logic [USED_W-1:0] used;
  } report_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    bit         pinned;  // want holds a hand-written result
    report_t    want;
  } row_t;

  localparam report_t NO_REPORT = '{CODE_GOOD, 16'd0, 16'd0, 11'd0};

  // Directed beats: finish on empty state, all-ones frame, checksum error,
  // short frame, then the average of the one good frame
  localparam row_t SCRIPT [25] = '{
    '{1'b1, 8'h00, 1'b1, '{CODE_NONE, 16'd0, 16'd0, 11'd0}},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},   // noise before any header
    '{1'b0, MARK_OPEN, 1'b0, NO_REPORT},
    '{1'b0, MARK_CMD, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'hFC, 1'b0, NO_REPORT},
    '{1'b0, MARK_TAIL, 1'b0, NO_REPORT},
    '{1'b0, MARK_OPEN, 1'b1, '{CODE_GOOD, 16'hFFFF, 16'hFFFF, 11'd1}},
    '{1'b0, MARK_CMD, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h01, 1'b0, NO_REPORT},   // checksum off by one
    '{1'b0, MARK_TAIL, 1'b0, NO_REPORT},
    '{1'b0, MARK_OPEN, 1'b1, '{CODE_CRC, 16'd0, 16'd0, 11'd1}},
    '{1'b0, MARK_OPEN, 1'b1, '{CODE_BAD, 16'd0, 16'd0, 11'd1}},
    '{1'b1, 8'h00, 1'b1, '{CODE_AVG, 16'hFFFF, 16'hFFFF, 11'd1}}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_op = 1'b0;
  logic [7:0]        in_data_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CODE_W-1:0] out_result_code;
  logic [PM_W-1:0]   out_pm25_tenths;
  logic [PM_W-1:0]   out_pm10_tenths;
  logic [USED_W-1:0] out_frames_used;

  // Predictor state
  logic [7:0]        kept [10] = '{default: 8'h00};
  logic [BCNT_W-1:0] kept_cnt = '0;
  bit                opened = 1'b0;
  logic [USED_W-1:0] good_cnt = '0;
  logic [25:0]       sum25 = '0;
  logic [25:0]       sum10 = '0;

  report_t pending_reports [$];
  int      fail_cnt = 0;
  int      beats_sent = 0;
  int      cycle_cnt = 0;
  int      src_gap_pct = 0;
  int      sink_stall_pct = 0;

  dust_sensor_frame_averager_core #(.MAX_FRAMES(FRAME_CAP)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_code (out_result_code),
    .out_pm25_tenths (out_pm25_tenths),
    .out_pm10_tenths (out_pm10_tenths),
    .out_frames_used (out_frames_used)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void flag_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("ERROR: %s", msg);
  endfunction

  // Frame parser and averager; returns 1 when the beat yields a result
  function automatic bit parse_and_average(input logic op, input logic [7:0] b,
                                           output report_t r);
    logic [7:0] csum;
    bit         made;
    made = 1'b0;
    r = NO_REPORT;
    if (op) begin
      if (good_cnt != 0) begin
        r.code = CODE_AVG;
        r.pm25 = PM_W'(sum25 / good_cnt);
        r.pm10 = PM_W'(sum10 / good_cnt);
        r.used = good_cnt;
      end else begin
        r.code = CODE_NONE;
      end
      kept_cnt = '0;
      opened   = 1'b0;
      good_cnt = '0;
      sum25    = '0;
      sum10    = '0;
      return 1'b1;
    end
    if (b == MARK_OPEN) begin
      if (!opened) begin
        opened = 1'b1;
      end else begin
        made = 1'b1;
        r.used = good_cnt;
        csum = kept[2] + kept[3] + kept[4] + kept[5] + kept[6] + kept[7];
        if (kept_cnt != FRAME_LEN || kept[1] != MARK_CMD || kept[9] != MARK_TAIL) begin
          r.code = CODE_BAD;
        end else if (csum != kept[8]) begin
          r.code = CODE_CRC;
        end else begin
          // saturated count: still reported, no longer summed
          if (good_cnt < FRAME_CAP) begin
            good_cnt++;
            sum25 += {kept[3], kept[2]};
            sum10 += {kept[5], kept[4]};
          end
          r.code = CODE_GOOD;
          r.pm25 = {kept[3], kept[2]};
          r.pm10 = {kept[5], kept[4]};
          r.used = good_cnt;
        end
      end
      kept_cnt = '0;
    end
    if (kept_cnt < FRAME_LEN) kept[kept_cnt] = b;
    if (kept_cnt <= FRAME_LEN) kept_cnt++;
    return made;
  endfunction

  // Drive one input beat; valid stays up across back-to-back beats
  task automatic send_beat(input logic op, input logic [7:0] b,
                           input bit pinned, input report_t want);
    report_t r;
    bit      made;
    if ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    made = parse_and_average(op, b, r);
    if (pinned) pending_reports.push_back(want);
    else if (made) pending_reports.push_back(r);
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  // Random sessions: a run of frames, usually closed, then a finish
  task automatic run_phase(input int gap_pct, input int stall_pct, input int quota);
    int         start_cnt;
    int         frames;
    int         kind;
    logic [7:0] body [9];
    logic [7:0] csum;
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
    start_cnt = beats_sent;
    while (beats_sent - start_cnt < quota) begin
      frames = ($urandom_range(7) == 0) ? FRAME_CAP + $urandom_range(6, 12)
                                        : $urandom_range(0, 6);
      for (int f = 0; f < frames && beats_sent - start_cnt < quota; f++) begin
        kind = $urandom_range(99);
        if (kind < 6) begin
          // line noise, may include stray markers
          repeat ($urandom_range(1, 4)) send_beat(1'b0, 8'($urandom_range(255)), 1'b0, NO_REPORT);
        end else if (kind < 14) begin
          // frame of arbitrary length and content
          send_beat(1'b0, MARK_OPEN, 1'b0, NO_REPORT);
          repeat ($urandom_range(0, 14)) send_beat(1'b0, 8'($urandom_range(255)), 1'b0, NO_REPORT);
        end else begin
          body[0] = MARK_CMD;
          for (int i = 1; i < 7; i++) body[i] = pick_byte();
          csum = body[1] + body[2] + body[3] + body[4] + body[5] + body[6];
          body[7] = csum;
          body[8] = MARK_TAIL;
          if (kind < 19) body[7] = csum + 8'($urandom_range(1, 255));
          else if (kind < 22) body[0] = MARK_CMD ^ 8'($urandom_range(1, 255));
          else if (kind < 25) body[8] = MARK_TAIL ^ 8'($urandom_range(1, 255));
          send_beat(1'b0, MARK_OPEN, 1'b0, NO_REPORT);
          for (int i = 0; i < 9; i++) send_beat(1'b0, body[i], 1'b0, NO_REPORT);
        end
      end
      if ($urandom_range(4) != 0) send_beat(1'b0, MARK_OPEN, 1'b0, NO_REPORT);
      send_beat(1'b1, 8'($urandom_range(255)), 1'b0, NO_REPORT);
    end
  endtask

  // Result side: random stalls, compare each beat with the oldest prediction
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        flag_fail($sformatf("unexpected result beat, code %0d", out_result_code));
      end else begin
        want = pending_reports.pop_front();
        if (out_result_code !== want.code || out_pm25_tenths !== want.pm25 ||
            out_pm10_tenths !== want.pm10 || out_frames_used !== want.used)
          flag_fail($sformatf(
            "code %0d/%0d pm25 %0d/%0d pm10 %0d/%0d used %0d/%0d (exp/got)",
            want.code, out_result_code, want.pm25, out_pm25_tenths,
            want.pm10, out_pm10_tenths, want.used, out_frames_used));
      end
    end
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("dust_sensor_frame_averager_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats
    src_gap_pct    = 19;
    sink_stall_pct = 60;
    foreach (SCRIPT[i])
      send_beat(SCRIPT[i].op, SCRIPT[i].data, SCRIPT[i].pinned, SCRIPT[i].want);

    // random traffic under three idle patterns
    run_phase(19, 60, 150);
    run_phase(60, 19, 150);
    run_phase(0, 0, 150);
    in_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("dust_sensor_frame_averager_core test passed");
    end else begin
      $display("dust_sensor_frame_averager_core test failed");
    end
    $finish;
  end

endmodule

@@ dust_sensor_frame_averager_core.f @@
rtl/dsfa_pkg.sv
rtl/dsfa_ctrl.sv
rtl/dsfa_div_lane.sv
rtl/dsfa_datapath.sv
rtl/dust_sensor_frame_averager_core.sv
bench/tb.sv
